// File: hw/rtl/aes_pkg.sv
// ----------------------------------------------------------------------------
// AES package
// Shared types, constants and the S-box function for the AES block.
// ----------------------------------------------------------------------------
package aes_pkg;

	localparam int KS_WORDS = 60;

	typedef enum logic [2:0] {
		REG_KEY_SIZE = 3'd0,
		REG_KEY_0    = 3'd1,
		REG_KEY_1    = 3'd2,
		REG_KEY_2    = 3'd3,
		REG_KEY_3    = 3'd4
	} reg_idx_t;

	localparam logic [1:0] KSZ_128 = 2'd0;
	localparam logic [1:0] KSZ_192 = 2'd1;
	localparam logic [1:0] KSZ_256 = 2'd2;

	// status from key expansion to the round engine
	typedef struct packed {
		logic       busy;
		logic [3:0] rounds;
	} key_status_t;

	function automatic logic [7:0] xt(input logic [7:0] v);
		xt = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] sbox(input logic [7:0] a);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		sbox = t[a];
	endfunction

endpackage

// File: hw/rtl/aes_block_encrypt.sv
// ----------------------------------------------------------------------------
// AES block encrypt
// ECB forward cipher for 128/192/256-bit keys with a serial column engine.
// ----------------------------------------------------------------------------
// One 128-bit block is taken at a time. The round engine handles one column
// per cycle plus a round key fetch step per round, its pace set by the single
// column unit and the one-word round key memory port. A new request is taken
// only once the engine's last ciphertext has moved to the output register.
// A ciphertext waiting in the output register does not block the next
// request; it only holds the engine's result once that is done. Each register
// write re-expands the key into 44 to 60 round key words, one word per cycle;
// after reset the same pass runs from the all-zero key. Input is held off
// during expansion, and register writes are held off while a block is in
// the engine.
module aes_block_encrypt import aes_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [63:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,   // plain_lower, plain_upper
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata    // cipher_lower, cipher_upper
);

	logic [1:0]   ksz_q;
	logic [255:0] key_q;
	logic         busy_q, res_q, wr, kstart, done, take, fwd;
	logic [5:0]   rk_addr;
	logic [31:0]  rk_data;
	logic [127:0] blk;
	key_status_t  kstat;

	assign cfg_ready = !busy_q;
	assign wr = cfg_valid && cfg_ready && cfg_index <= REG_KEY_3;
	assign kstart = wr;
	assign s_tready = !busy_q && !kstat.busy && !wr;
	assign take = s_tvalid && s_tready;
	// move the engine result to the output register once it is free
	assign fwd = (done || res_q) && (!m_tvalid || m_tready);

	// hold configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ksz_q <= '0;
			key_q <= '0;
		end else if (wr) begin
			if (cfg_index == REG_KEY_SIZE) ksz_q <= cfg_data[1:0];
			else key_q[255 - 64*(cfg_index - 3'd1) -: 64] <= cfg_data;
		end
	end

	// track one request in the engine and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			res_q <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (take) busy_q <= 1'b1;
			else if (fwd) busy_q <= 1'b0;
			res_q <= (done || res_q) && !fwd;
			if (fwd) m_tvalid <= 1'b1;
			else if (m_tready) m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) if (fwd) m_tdata <= {blk[63:0], blk[127:64]};

	aes_key_exp u_key (.clk, .arst_n, .start(kstart), .key_size_mode(ksz_q),
		.key(key_q), .rd_addr(rk_addr), .rd_data(rk_data), .status(kstat));

	aes_round u_rnd (.clk, .arst_n, .start(take),
		.block_in({s_tdata[63:0], s_tdata[127:64]}), .kstat, .rk_addr, .rk_data,
		.done, .block_out(blk));

endmodule

// File: hw/rtl/aes_key_exp.sv
// ----------------------------------------------------------------------------
// AES key expansion
// Expands the cipher key one word per cycle into the round key memory and
// serves one round key word per cycle to the round engine.
// ----------------------------------------------------------------------------
module aes_key_exp import aes_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [1:0]        key_size_mode,
	input  logic [255:0]      key,
	input  logic [5:0]        rd_addr,
	output logic [31:0]       rd_data,
	output key_status_t       status
);

	logic [31:0] mem [KS_WORDS];
	logic [31:0] win_q [8];        // last nk words, newest at index 0
	logic [5:0]  idx_q;
	logic [2:0]  mod_q;            // idx mod nk
	logic [7:0]  rcon_q;
	logic        busy_q;
	logic [3:0]  nk;
	logic [5:0]  total;
	logic [31:0] prev, t, nw, kw;

	always_comb begin
		unique case (key_size_mode)
			KSZ_192: begin nk = 4'd6; status.rounds = 4'd12; end
			KSZ_256: begin nk = 4'd8; status.rounds = 4'd14; end
			default: begin nk = 4'd4; status.rounds = 4'd10; end
		endcase
		total = {status.rounds, 2'b00} + 6'd4;
		status.busy = busy_q;
		prev = win_q[0];
		t = prev;
		if (mod_q == 3'd0)
			t = {sbox(prev[23:16]), sbox(prev[15:8]), sbox(prev[7:0]), sbox(prev[31:24])}
				^ {rcon_q, 24'd0};
		else if (nk == 4'd8 && mod_q == 3'd4)
			t = {sbox(prev[31:24]), sbox(prev[23:16]), sbox(prev[15:8]), sbox(prev[7:0])};
		nw = win_q[nk[2:0] - 3'd1] ^ t;
		kw = key[255 - 32*idx_q[2:0] -: 32];
	end

	// step the schedule one word per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
			mod_q  <= '0;
			rcon_q <= 8'h01;
		end else if (start) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
			mod_q  <= '0;
			rcon_q <= 8'h01;
		end else if (busy_q) begin
			idx_q <= idx_q + 6'd1;
			mod_q <= (mod_q == nk[2:0] - 3'd1) ? 3'd0 : mod_q + 3'd1;
			if (idx_q >= {2'b00, nk} && mod_q == 3'd0) rcon_q <= xt(rcon_q);
			if (idx_q == total - 6'd1) busy_q <= 1'b0;
		end
	end

	// write memory and shift the word window
	always_ff @(posedge clk) begin
		if (busy_q && !start) begin
			if (idx_q < {2'b00, nk}) begin
				mem[idx_q] <= kw;
				win_q[0] <= kw;
			end else begin
				mem[idx_q] <= nw;
				win_q[0] <= nw;
			end
			for (int j = 1; j < 8; j++) win_q[j] <= win_q[j-1];
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// File: hw/rtl/aes_round.sv
// ----------------------------------------------------------------------------
// AES round engine
// Runs one column of one round per cycle: after the initial key addition, each
// column gets ShiftRows, SubBytes, MixColumns (not last round) and AddRoundKey.
// ----------------------------------------------------------------------------
module aes_round import aes_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [127:0]      block_in,
	input  key_status_t       kstat,
	output logic [5:0]        rk_addr,
	input  logic [31:0]       rk_data,
	output logic              done,
	output logic [127:0]      block_out
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_ARK  = 3'b010,
		ST_RND  = 3'b100
	} state_t;

	state_t      st_q;
	logic [127:0] s_q;          // current state, column 0 in top bits
	logic [127:0] n_q;          // next state columns being built
	logic [3:0]  rnd_q;
	logic [2:0]  col_q;         // 0..3 compute, 1..4 add key; 0 leads the key fetch
	logic [31:0] colv, subc, mixc;
	logic [7:0]  a0, a1, a2, a3;
	logic [31:0]  mixc_q;
	logic [127:0] n_next;

	// round key address runs ahead of the column by the registered memory read
	assign rk_addr = {rnd_q, col_q[1:0]};

	always_comb begin
		// gather the shifted column c: byte r from column (c+r)&3
		for (int r = 0; r < 4; r++)
			colv[31-8*r -: 8] = s_q[127 - 32*((col_q[1:0] + r) & 3) - 8*r -: 8];
		for (int r = 0; r < 4; r++)
			subc[31-8*r -: 8] = sbox(colv[31-8*r -: 8]);
		a0 = subc[31:24]; a1 = subc[23:16]; a2 = subc[15:8]; a3 = subc[7:0];
		mixc = {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
			a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
			a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
			xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
		if (rnd_q == kstat.rounds) mixc = subc;
	end

	// sequence rounds and columns
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_IDLE;
			rnd_q <= '0;
			col_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (st_q)
				ST_IDLE: if (start) begin
					st_q  <= ST_ARK;
					rnd_q <= '0;
					col_q <= 3'd0;
				end
				ST_ARK: begin
					// initial key addition, words 0..3 one per cycle
					col_q <= col_q + 3'd1;
					if (col_q == 3'd4) begin
						st_q <= ST_RND;
						rnd_q <= 4'd1;
						col_q <= 3'd0;
					end
				end
				ST_RND: begin
					col_q <= col_q + 3'd1;
					if (col_q == 3'd4) begin
						col_q <= 3'd0;
						if (rnd_q == kstat.rounds) begin
							st_q <= ST_IDLE;
							done <= 1'b1;
						end else rnd_q <= rnd_q + 4'd1;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// column datapath; rk_data belongs to the column of the previous cycle
	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && start) s_q <= block_in;
		else if (st_q != ST_IDLE && col_q != 3'd0) begin
			if (st_q == ST_ARK)
				n_q <= {n_q[95:0], s_q[127 - 32*(col_q - 3'd1) -: 32] ^ rk_data};
			else
				n_q <= {n_q[95:0], mixc_q ^ rk_data};
		end
		mixc_q <= mixc;
		if (st_q != ST_IDLE && col_q == 3'd4) s_q <= n_next;
	end

	always_comb begin
		if (st_q == ST_ARK) n_next = {n_q[95:0], s_q[31:0] ^ rk_data};
		else n_next = {n_q[95:0], mixc_q ^ rk_data};
	end

	assign block_out = s_q;

	ap_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> st_q == ST_IDLE) else $error("done outside idle");
	ap_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= 3'd4) else $error("column counter out of range");
	ap_rnd_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_RND |-> rnd_q >= 4'd1 && rnd_q <= kstat.rounds)
		else $error("round out of range");

endmodule

// File: sim/aes_block_encrypt_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// AES block encrypt testbench
// Drives plaintext requests and key writes into the ECB cipher, predicts each
// ciphertext from an in-bench key schedule and round model, and compares.
// ----------------------------------------------------------------------------
module aes_block_encrypt_tb;
	import aes_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int DRAIN_CYCLES = 200;

	logic         clk;
	logic         arst_n;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [2:0]   cfg_index;
	logic [63:0]  cfg_data;
	logic         s_tvalid;
	logic         s_tready;
	logic [127:0] s_tdata;   // plain_lower, plain_upper
	logic         m_tvalid;
	logic         m_tready;
	logic [127:0] m_tdata;   // cipher_lower, cipher_upper

	typedef struct packed {
		logic [63:0] lower;
		logic [63:0] upper;
	} block_t;

	// predictor copy of the configuration and key schedule
	logic [1:0]  key_size;
	logic [63:0] key_regs [4];
	logic [31:0] sched [KS_WORDS];
	int          num_rounds;

	block_t cipher_q [$];
	int     err_count;
	int     cycle_count;
	int     send_idle_pct;
	int     recv_idle_pct;
	logic [7:0] sb [256];

	aes_block_encrypt uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #5 clk = ~clk;

	function automatic logic [7:0] gmul2(input logic [7:0] v);
		return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
	endfunction

	// build the S-box from the field inverse and affine map
	task automatic build_sbox();
		logic [7:0] p, q;
		p = 8'h01;
		q = 8'h01;
		do begin
			p = p ^ gmul2(p);
			q = q ^ {q[6:0], 1'b0};
			q = q ^ {q[5:0], 2'b0};
			q = q ^ {q[3:0], 4'b0};
			if (q[7])
				q = q ^ 8'h09;
			sb[p] = q ^ {q[6:0], q[7]} ^ {q[5:0], q[7:6]} ^ {q[4:0], q[7:5]}
				^ {q[3:0], q[7:4]} ^ 8'h63;
		end while (p != 8'h01);
		sb[0] = 8'h63;
	endtask

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {sb[w[31:24]], sb[w[23:16]], sb[w[15:8]], sb[w[7:0]]};
	endfunction

	// rebuild the round keys from the current key registers
	task automatic expand_schedule();
		int nk, total;
		logic [7:0] rc;
		logic [31:0] t;
		rc = 8'h01;
		case (key_size)
			KSZ_192: begin nk = 6; num_rounds = 12; end
			KSZ_256: begin nk = 8; num_rounds = 14; end
			default: begin nk = 4; num_rounds = 10; end
		endcase
		total = 4 * (num_rounds + 1);
		for (int i = 0; i < KS_WORDS; i++)
			sched[i] = '0;
		for (int i = 0; i < nk; i++)
			sched[i] = i[0] ? key_regs[i >> 1][31:0] : key_regs[i >> 1][63:32];
		for (int i = nk; i < total; i++) begin
			t = sched[i - 1];
			if (i % nk == 0) begin
				t = sub_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
				rc = gmul2(rc);
			end else if (nk == 8 && i % nk == 4) begin
				t = sub_word(t);
			end
			sched[i] = sched[i - nk] ^ t;
		end
	endtask

	function automatic block_t encrypt_block(input block_t pt);
		logic [7:0] s [16];
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3;
		block_t ct;
		for (int i = 0; i < 8; i++) begin
			s[i] = pt.upper[63 - 8*i -: 8];
			s[8 + i] = pt.lower[63 - 8*i -: 8];
		end
		for (int rnd = 0; rnd <= num_rounds; rnd++) begin
			if (rnd > 0) begin
				for (int c = 0; c < 4; c++)
					for (int r = 0; r < 4; r++)
						t[4*c + r] = sb[s[4*((c + r) % 4) + r]];
				s = t;
			end
			if (rnd > 0 && rnd < num_rounds) begin
				for (int c = 0; c < 4; c++) begin
					a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
					s[4*c]   = gmul2(a0) ^ gmul2(a1) ^ a1 ^ a2 ^ a3;
					s[4*c+1] = a0 ^ gmul2(a1) ^ gmul2(a2) ^ a2 ^ a3;
					s[4*c+2] = a0 ^ a1 ^ gmul2(a2) ^ gmul2(a3) ^ a3;
					s[4*c+3] = gmul2(a0) ^ a0 ^ a1 ^ a2 ^ gmul2(a3);
				end
			end
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 4; r++)
					s[4*c + r] ^= sched[(rnd*4 + c) % KS_WORDS][31 - 8*r -: 8];
		end
		for (int i = 0; i < 8; i++) begin
			ct.upper[63 - 8*i -: 8] = s[i];
			ct.lower[63 - 8*i -: 8] = s[8 + i];
		end
		return ct;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		err_count++;
	endtask

	// drop the request, wait until every ciphertext has come back, then settle
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (cipher_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// write one key register while idle; the caller drops cfg_valid
	task automatic write_reg(input reg_idx_t idx, input logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		if (idx == REG_KEY_SIZE)
			key_size = val[1:0];
		else
			key_regs[idx - REG_KEY_0] = val;
		expand_schedule();
	endtask

	task automatic load_key(input logic [1:0] ksz, input logic [63:0] k0,
		input logic [63:0] k1, input logic [63:0] k2, input logic [63:0] k3);
		wait_drained();
		write_reg(REG_KEY_SIZE, {62'h0, ksz});
		write_reg(REG_KEY_0, k0);
		write_reg(REG_KEY_1, k1);
		write_reg(REG_KEY_2, k2);
		write_reg(REG_KEY_3, k3);
		cfg_valid <= 1'b0;
	endtask

	// send one plaintext request, with a random hold-off before it
	task automatic send_block(input block_t pt);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= pt;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		cipher_q = {cipher_q, encrypt_block(pt)};
		@(negedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// check each ciphertext against the oldest prediction
	always @(posedge clk) begin
		block_t got, want;
		if (m_tvalid && m_tready) begin
			got = m_tdata;
			if (cipher_q.size() == 0) begin
				report_mismatch("unexpected cipher_upper", got.upper, '0);
			end else begin
				want = cipher_q.pop_front();
				if (got.upper !== want.upper)
					report_mismatch("cipher_upper", got.upper, want.upper);
				if (got.lower !== want.lower)
					report_mismatch("cipher_lower", got.lower, want.lower);
			end
		end
	end

	// randomly stall the output
	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= recv_idle_pct);

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("aes_block_encrypt_tb NOT OK");
			$finish;
		end
	end

	// known answer vectors from the standard, one per key size
	task automatic test_known_answers();
		block_t pt;
		pt = {64'h8899aabbccddeeff, 64'h0011223344556677};
		load_key(KSZ_128, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
			64'hffffffffffffffff, 64'hffffffffffffffff);
		send_block(pt);
		load_key(KSZ_192, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
			64'h1011121314151617, 64'hffffffffffffffff);
		send_block(pt);
		load_key(KSZ_256, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
			64'h1011121314151617, 64'h18191a1b1c1d1e1f);
		send_block(pt);
	endtask

	// all-zero and all-one data and keys, unused key size code
	task automatic test_extremes();
		send_block('0);
		send_block('1);
		load_key(2'd3, '1, '1, '0, '0);
		send_block('0);
		send_block('1);
		send_block({64'h0, 64'h8000000000000001});
		load_key(KSZ_256, '1, '1, '1, '1);
		send_block('1);
		send_block('0);
		load_key(KSZ_128, '0, '0, '0, '0);
		send_block('0);
	endtask

	// random plaintext under random keys of every size
	task automatic test_random(input int count);
		block_t pt;
		for (int i = 0; i < count; i++) begin
			if (i % 100 == 0)
				load_key(2'($urandom_range(3)), rand64(), rand64(), rand64(), rand64());
			pt = {rand64(), rand64()};
			send_block(pt);
			if (i % 250 == 125)
				wait_drained();
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_KEY_SIZE;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		err_count = 0;
		cycle_count = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		key_size = KSZ_128;
		for (int i = 0; i < 4; i++)
			key_regs[i] = '0;
		build_sbox();
		expand_schedule();
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 27;
		recv_idle_pct = 87;
		test_extremes();
		test_known_answers();
		test_random(550);

		send_idle_pct = 87;
		recv_idle_pct = 27;
		test_random(550);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(600);

		wait_drained();
		if (err_count == 0)
			$display("aes_block_encrypt_tb OK");
		else
			$display("aes_block_encrypt_tb NOT OK");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/aes_pkg.sv
hw/rtl/aes_key_exp.sv
hw/rtl/aes_round.sv
hw/rtl/aes_block_encrypt.sv
sim/aes_block_encrypt_tb.sv
